>>> design/assert_macros.svh
// Assertion helpers for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define KMA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define KMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/kma_pkg.sv
`timescale 1ns / 1ps
package kma_pkg;
  localparam int unsigned Window      = 8;
  localparam int unsigned TickerChars = 8;
  localparam int unsigned PriceW      = 32;
  localparam int unsigned TickerW     = 64;

  localparam logic [1:0] KindPrice = 2'd0;
  localparam logic [1:0] KindEnd   = 2'd1;

  localparam logic [1:0] StatusRecord  = 2'd0;
  localparam logic [1:0] StatusDone    = 2'd1;
  localparam logic [1:0] StatusUnknown = 2'd2;

  localparam logic [22:0] PercentQ16 = 23'd6553600;
  localparam logic [31:0] ChangeMax  = 32'h7FFF_FFFF;

  localparam int unsigned DivW = 64;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

>>> design/keyed_moving_average_and_change.sv
`timescale 1ns / 1ps
// A price transaction passes StPct, StPctWait, StAvg, StAvgWait and StOut before
// its result is valid (two 64-step radix-2 divisions on the single shared divider);
// end-of-stream and unknown kinds are valid in the next cycle. Input waits until a price
// transaction is back in StIdle; end and unknown ones can follow every cycle unless stalled.
// Reset clears ticker, previous price, window count, position, sum and all window
// entries at once.
`include "assert_macros.svh"
module keyed_moving_average_and_change #(
  parameter int unsigned WINDOW       = kma_pkg::Window,
  parameter int unsigned TICKER_CHARS = kma_pkg::TickerChars
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] ticker_code_i,
  input  logic [31:0] date_tag_i,
  input  logic [31:0] price_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] ticker_out_o,
  output logic [31:0] date_out_o,
  output logic [31:0] price_out_o,
  output logic signed [31:0] pct_change_o,
  output logic        change_invalid_o,
  output logic [31:0] moving_average_o
);
  localparam int unsigned PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned SumW = 32 + CntW;
  localparam logic [63:0] TickMask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - 8 * TICKER_CHARS);

  typedef enum logic [2:0] {
    StIdle, StPct, StPctWait, StAvg, StAvgWait, StOut
  } state_e;

  state_e state_q;
  logic [63:0] cur_tick_q;
  logic [31:0] prev_q;
  logic [31:0] win_q [WINDOW];
  logic [CntW-1:0] cnt_q;
  logic [PosW-1:0] pos_q;
  logic [SumW-1:0] sum_q;

  logic [63:0] tick_q;
  logic [31:0] date_q, price_q;
  logic        neg_q, skip_q;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [63:0] tick_out_q;
  logic [31:0] date_out_q, price_out_q, chg_q, avg_q;
  logic        inv_q;

  kma_pkg::div_ctl_t div_ctl;
  logic [kma_pkg::DivW-1:0] div_a, div_b, div_q;

  logic        in_acc;
  logic        out_set;
  logic [63:0] tick_in;
  logic [31:0] mag;
  logic        new_tick;
  logic [31:0] prev_eff;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_set    = ((state_q == StIdle) && in_acc && (kind_i != kma_pkg::KindPrice)) ||
                      ((state_q == StOut) && (!out_valid_q || !out_stall_i));
  assign tick_in    = ticker_code_i & TickMask;
  assign new_tick   = (tick_in != cur_tick_q);
  assign prev_eff   = new_tick ? price_i : prev_q;
  assign mag        = (price_q < prev_q) ? (prev_q - price_q) : (price_q - prev_q);

  always_comb begin
    div_ctl.start = (state_q == StPct) || (state_q == StAvg);
    div_a = '0;
    div_b = '0;
    if (state_q == StPct) begin
      div_a = 64'(mag) * 64'(kma_pkg::PercentQ16);
      div_b = 64'(prev_q);
    end else begin
      div_a = 64'(sum_q);
      div_b = 64'(cnt_q);
    end
  end

  kma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctl.start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_ctl.busy),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cur_tick_q  <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
      status_q    <= '0;
      tick_q      <= '0;
      date_q      <= '0;
      price_q     <= '0;
      neg_q       <= 1'b0;
      skip_q      <= 1'b0;
      tick_out_q  <= '0;
      date_out_q  <= '0;
      price_out_q <= '0;
      chg_q       <= '0;
      avg_q       <= '0;
      inv_q       <= 1'b0;
    end else begin
      if (out_set) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            tick_q  <= tick_in;
            date_q  <= date_tag_i;
            price_q <= price_i;
            if (kind_i == kma_pkg::KindPrice) begin
              skip_q <= new_tick || (cnt_q == '0) || (prev_eff == '0);
              inv_q  <= !(new_tick || (cnt_q == '0)) && (prev_eff == '0);
              neg_q  <= price_i < prev_eff;
              prev_q <= prev_eff;
              if (new_tick) begin
                cur_tick_q <= tick_in;
                cnt_q      <= '0;
                pos_q      <= '0;
                sum_q      <= '0;
                for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
              end
              state_q <= StPct;
            end else begin
              status_q    <= (kind_i == kma_pkg::KindEnd) ? kma_pkg::StatusDone
                                                         : kma_pkg::StatusUnknown;
              tick_out_q  <= '0;
              date_out_q  <= '0;
              price_out_q <= '0;
              chg_q       <= '0;
              inv_q       <= 1'b0;
              avg_q       <= '0;
            end
          end
        end
        StPct: state_q <= StPctWait;
        StPctWait: begin
          if (!div_ctl.busy) begin
            if (skip_q) begin
              chg_q <= '0;
            end else if (neg_q) begin
              chg_q <= 32'(0) - div_q[31:0];
            end else if (div_q > 64'(kma_pkg::ChangeMax)) begin
              chg_q <= kma_pkg::ChangeMax;
              inv_q <= 1'b1;
            end else begin
              chg_q <= div_q[31:0];
            end
            sum_q <= sum_q - SumW'(win_q[pos_q]) + SumW'(price_q);
            win_q[pos_q] <= price_q;
            pos_q <= (32'(pos_q) + 1 >= WINDOW) ? '0 : pos_q + 1'b1;
            if (32'(cnt_q) < WINDOW) cnt_q <= cnt_q + 1'b1;
            prev_q  <= price_q;
            state_q <= StAvg;
          end
        end
        StAvg: state_q <= StAvgWait;
        StAvgWait: begin
          if (!div_ctl.busy) begin
            avg_q   <= div_q[31:0];
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            status_q    <= kma_pkg::StatusRecord;
            tick_out_q  <= tick_q;
            date_out_q  <= date_q;
            price_out_q <= price_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign ticker_out_o     = tick_out_q;
  assign date_out_o       = date_out_q;
  assign price_out_o      = price_out_q;
  assign pct_change_o     = chg_q;
  assign change_invalid_o = inv_q;
  assign moving_average_o = avg_q;

  `KMA_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != StIdle, in_stall_o, "accept while busy")
  `KMA_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, 32'(cnt_q) <= WINDOW, "fill count out of range")
  `KMA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q && $stable(avg_q), "result dropped")
endmodule

>>> design/kma_div.sv
`timescale 1ns / 1ps
module kma_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [kma_pkg::DivW-1:0]   dividend_i,
  input  logic [kma_pkg::DivW-1:0]   divisor_i,
  output logic                       busy_o,
  output logic [kma_pkg::DivW-1:0]   quot_o
);
  localparam int unsigned CntW = $clog2(kma_pkg::DivW + 1);

  logic [kma_pkg::DivW-1:0] quot_q, quot_d;
  logic [kma_pkg::DivW:0]   rem_q, rem_d;
  logic [kma_pkg::DivW-1:0] dsr_q;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [kma_pkg::DivW:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    trial  = {rem_q[kma_pkg::DivW-1:0], quot_q[kma_pkg::DivW-1]} - {1'b0, dsr_q};
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      cnt_d  = CntW'(kma_pkg::DivW);
    end else if (cnt_q != '0) begin
      if (!trial[kma_pkg::DivW]) begin
        rem_d  = trial;
        quot_d = {quot_q[kma_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[kma_pkg::DivW-1:0], quot_q[kma_pkg::DivW-1]};
        quot_d = {quot_q[kma_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule
